/* src/tbam_pkg.sv */
// Shared types and constants for the translated block address map.
// Used by the register block, the controller, the datapath and the top level.
// Depends on nothing else.
package tbam_pkg;

  // Table geometry and derived widths.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int GS_W = $clog2(TABLE_DEPTH * 15 + 1);
  localparam int NS_W = $clog2(TABLE_DEPTH * 60 + 1);

  // Field widths and special values.
  localparam int ADDR_W = 64;
  localparam int GLEN_W = 16;
  localparam int GIDX_W = 10;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;
  localparam logic [3:0] CONT_CODE = 4'd15;
  localparam int NATIVE_INSN_BYTES = 4;
  localparam int NATIVE_SHIFT = $clog2(NATIVE_INSN_BYTES);
  localparam int GIDX_SAT = 511;

  // Item functions.
  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_N2G  = 2'd1,
    FUNC_G2I  = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_GUEST_BASE   = 2'd0,
    REG_NATIVE_BASE  = 2'd1,
    REG_NATIVE_LIMIT = 2'd2,
    REG_GUEST_LENGTH = 2'd3
  } reg_idx_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_CMP,
    ST_FINISH
  } state_t;

  // Configuration values as seen by the datapath.
  typedef struct packed {
    logic [ADDR_W-1:0] guest_base;
    logic [ADDR_W-1:0] native_base;
    logic [ADDR_W-1:0] native_limit;
    logic [GLEN_W-1:0] guest_length;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic check;
    logic walk_start;
    logic walk_step;
    logic cmp_step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic query_ok;
    logic group_end;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

/* src/tbam_regs.sv */
// Configuration registers of the translated block address map on an APB-style port.
// Depends on tbam_pkg.
module tbam_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbam_pkg::PADDR_W-1:0]  paddr,
  input  logic [tbam_pkg::PDATA_W-1:0]  pwdata,
  output logic [tbam_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output tbam_pkg::cfg_t                cfg
);
  import tbam_pkg::*;

  logic [ADDR_W-1:0] guest_base_r;
  logic [ADDR_W-1:0] native_base_r;
  logic [ADDR_W-1:0] native_limit_r;
  logic [GLEN_W-1:0] guest_length_r;
  logic              wr_en;
  reg_idx_t          reg_idx;

  // Registers sit on 8-byte boundaries; the low address bits are ignored.
  assign reg_idx = reg_idx_t'(paddr[4:3]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guest_base_r   <= '0;
      native_base_r  <= '0;
      native_limit_r <= '0;
      guest_length_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GUEST_BASE:   guest_base_r   <= pwdata;
        REG_NATIVE_BASE:  native_base_r  <= pwdata;
        REG_NATIVE_LIMIT: native_limit_r <= pwdata;
        REG_GUEST_LENGTH: guest_length_r <= pwdata[GLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      REG_GUEST_BASE:   prdata = guest_base_r;
      REG_NATIVE_BASE:  prdata = native_base_r;
      REG_NATIVE_LIMIT: prdata = native_limit_r;
      REG_GUEST_LENGTH: prdata = PDATA_W'(guest_length_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.guest_base   = guest_base_r;
  assign cfg.native_base  = native_base_r;
  assign cfg.native_limit = native_limit_r;
  assign cfg.guest_length = guest_length_r;

endmodule

/* src/tbam_ctrl.sv */
// Controller state machine for the translated block address map.
// Sequences capture, range check, table walk and result hand-off. Depends on tbam_pkg.
module tbam_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tbam_pkg::sts_t sts,
  output tbam_pkg::cmd_t cmd
);
  import tbam_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.query_ok) begin
          cmd.walk_start = 1'b1;
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.group_end) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.cmp_step = 1'b1;
        if (sts.walk_done) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* src/tbam_dp.sv */
// Datapath of the translated block address map: size table memory, walk
// accumulators, range checks and the output register. Depends on tbam_pkg.
module tbam_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tbam_pkg::cfg_t                 cfg,
  input  tbam_pkg::cmd_t                 cmd,
  output tbam_pkg::sts_t                 sts,
  input  logic [1:0]                     in_func,
  input  logic [7:0]                     in_entry_slot,
  input  logic [3:0]                     in_entry_guest_len,
  input  logic [3:0]                     in_entry_native_count,
  input  logic [tbam_pkg::ADDR_W-1:0]    in_query_addr,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tbam_pkg::ADDR_W-1:0]    out_guest_addr,
  output logic signed [tbam_pkg::GIDX_W-1:0] out_group_index,
  output logic                           out_out_of_range
);
  import tbam_pkg::*;

  // Size table: guest length in the low nibble, native count in the high nibble.
  logic [7:0]        mem [TABLE_DEPTH];
  logic [7:0]        mem_q_r;
  logic [IDX_W-1:0]  rd_addr;
  logic [31:0]       slot_ext;
  logic              load_en;

  // Captured item.
  func_t             func_r;
  logic [ADDR_W-1:0] q_r;

  // Walk state.
  logic [ADDR_W-1:0] g_r;
  logic [ADDR_W-1:0] n_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [GS_W-1:0]   gs_r;
  logic [NS_W-1:0]   ns_r;
  logic [IDX_W:0]    i_r;

  // Result and output registers.
  logic [ADDR_W-1:0] res_gaddr_r;
  logic [GIDX_W-1:0] res_idx_r;
  logic              res_oor_r;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_gaddr_r;
  logic [GIDX_W-1:0] out_idx_r;
  logic              out_oor_r;

  // Combinational helpers.
  logic              by_guest;
  logic              oor;
  logic [ADDR_W-1:0] guest_top;
  logic [3:0]        ent_gl;
  logic [3:0]        ent_nc;
  logic              ent_more;
  logic              last_entry;
  logic              table_end;
  logic [ADDR_W-1:0] cmp_base;
  logic [ADDR_W-1:0] cmp_end;
  logic              hit;
  logic              term;
  logic [ADDR_W-1:0] g_adv;
  logic [ADDR_W-1:0] n_adv;
  logic [CNT_W-1:0]  cnt_inc;
  logic [GIDX_W-1:0] idx_hit;
  logic [GIDX_W-1:0] idx_term;

  // Table write on an accepted load beat.
  assign slot_ext = 32'(in_entry_slot);
  assign load_en = cmd.capture && (func_t'(in_func) == FUNC_LOAD) &&
                   (slot_ext < 32'(TABLE_DEPTH));

  // Read address: the walk streams one entry per cycle, and the compare
  // step rereads the first entry of the next group.
  always_comb begin
    if (cmd.walk_start) begin
      rd_addr = '0;
    end else if (cmd.walk_step) begin
      rd_addr = IDX_W'(i_r + (IDX_W+1)'(1));
    end else begin
      rd_addr = i_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      mem[slot_ext[IDX_W-1:0]] <= {in_entry_native_count, in_entry_guest_len};
    end
    mem_q_r <= mem[rd_addr];
  end

  // Range check on the captured query.
  assign by_guest  = (func_r == FUNC_G2I);
  assign guest_top = cfg.guest_base + ADDR_W'(cfg.guest_length);
  always_comb begin
    unique case (func_r)
      FUNC_N2G: oor = (q_r < cfg.native_base) || (q_r > cfg.native_limit);
      FUNC_G2I: oor = (q_r < cfg.guest_base) || (q_r > guest_top);
      default:  oor = 1'b0;
    endcase
  end
  assign sts.query_ok = ((func_r == FUNC_N2G) || (func_r == FUNC_G2I)) && !oor;

  // One table entry per walk step.
  assign ent_gl     = mem_q_r[3:0];
  assign ent_nc     = mem_q_r[7:4];
  assign ent_more   = (ent_gl == CONT_CODE) || (ent_nc == CONT_CODE);
  assign last_entry = (i_r == (IDX_W+1)'(TABLE_DEPTH - 1));
  assign sts.group_end = !ent_more || last_entry;

  // Group compare against the address window of the closed group.
  assign table_end = (i_r == (IDX_W+1)'(TABLE_DEPTH));
  assign cmp_base  = by_guest ? g_r : n_r;
  assign cmp_end   = by_guest ? (g_r + ADDR_W'(gs_r)) : (n_r + ADDR_W'(ns_r));
  assign hit       = (q_r >= cmp_base) && (q_r < cmp_end);
  assign term      = table_end || (mem_q_r == 8'd0);
  assign sts.walk_done = hit || term;
  assign g_adv     = g_r + ADDR_W'(gs_r);
  assign n_adv     = n_r + ADDR_W'(ns_r);
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign idx_hit   = (32'(cnt_r) > 32'(GIDX_SAT)) ? GIDX_W'(GIDX_SAT) : GIDX_W'(cnt_r);
  assign idx_term  = (32'(cnt_inc) > 32'(GIDX_SAT)) ? GIDX_W'(GIDX_SAT) : GIDX_W'(cnt_inc);

  // Captured item, walk registers and result registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func_t'(in_func);
      q_r    <= in_query_addr;
    end
    if (cmd.check) begin
      res_gaddr_r <= '0;
      res_idx_r   <= (by_guest && oor) ? '1 : '0;
      res_oor_r   <= oor;
    end
    if (cmd.walk_start) begin
      g_r   <= cfg.guest_base;
      n_r   <= cfg.native_base;
      cnt_r <= '0;
      gs_r  <= '0;
      ns_r  <= '0;
      i_r   <= '0;
    end else if (cmd.walk_step) begin
      gs_r <= gs_r + GS_W'(ent_gl);
      ns_r <= ns_r + (NS_W'(ent_nc) << NATIVE_SHIFT);
      i_r  <= i_r + (IDX_W+1)'(1);
    end else if (cmd.cmp_step) begin
      if (hit) begin
        if (by_guest) begin
          res_idx_r <= idx_hit;
        end else begin
          res_gaddr_r <= g_r;
        end
      end else begin
        g_r   <= g_adv;
        n_r   <= n_adv;
        cnt_r <= cnt_inc;
        gs_r  <= '0;
        ns_r  <= '0;
        if (term) begin
          if (by_guest) begin
            res_idx_r <= idx_term;
          end else begin
            res_gaddr_r <= g_adv;
          end
        end
      end
    end
  end

  // Output register: holds a finished beat until the sink takes it.
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_gaddr_r <= res_gaddr_r;
      out_idx_r   <= res_idx_r;
      out_oor_r   <= res_oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_guest_addr   = out_gaddr_r;
  assign out_group_index  = $signed(out_idx_r);
  assign out_out_of_range = out_oor_r;

endmodule

/* src/translated_block_address_map.sv */
// A load or unknown function goes through check and finish states to output valid; a query
// in range also walks the table group by group, one size-table read per cycle, comparing each group.
// Throughput: one item at a time; the next beat is accepted once the result is in the
// output register, which holds it while the sink stalls.
// Reset: synchronous active-low rst_n clears the controller, output valid and the
// configuration registers; the size table is not cleared and must be loaded before use.
module translated_block_address_map (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_func,
  input  logic [7:0]                         in_entry_slot,
  input  logic [3:0]                         in_entry_guest_len,
  input  logic [3:0]                         in_entry_native_count,
  input  logic [tbam_pkg::ADDR_W-1:0]        in_query_addr,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tbam_pkg::ADDR_W-1:0]        out_guest_addr,
  output logic signed [tbam_pkg::GIDX_W-1:0] out_group_index,
  output logic                               out_out_of_range,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tbam_pkg::PADDR_W-1:0]       paddr,
  input  logic [tbam_pkg::PDATA_W-1:0]       pwdata,
  output logic [tbam_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);
  import tbam_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers.
  tbam_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer.
  tbam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, walk arithmetic and output register.
  tbam_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_func               (in_func),
    .in_entry_slot         (in_entry_slot),
    .in_entry_guest_len    (in_entry_guest_len),
    .in_entry_native_count (in_entry_native_count),
    .in_query_addr         (in_query_addr),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_guest_addr        (out_guest_addr),
    .out_group_index       (out_group_index),
    .out_out_of_range      (out_out_of_range)
  );

endmodule
